>>> rtl/bdgj_pkg.sv
// Shared types and constants for the backoff deadline gate with jitter.
package bdgj_pkg;

  // Input transaction fields.
  typedef struct packed {
    logic        operation;
    logic [63:0] now_ns;
    logic [9:0]  status_code;
    logic        hint_valid;
    logic [31:0] hint_ms;
  } req_t;

  // Result transaction fields.
  typedef struct packed {
    logic        verdict;
    logic [44:0] remaining_ms;
  } rsp_t;

  // Status of the serial divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Operation codes.
  localparam logic OP_CHECK    = 1'b0;
  localparam logic OP_RESPONSE = 1'b1;

  // Configuration register indexes.
  localparam logic REG_MAX_BACKOFF     = 1'b0;
  localparam logic REG_DEFAULT_BACKOFF = 1'b1;

  // Status codes that arm the window.
  localparam logic [9:0] STATUS_TOO_MANY    = 10'd429;
  localparam logic [9:0] STATUS_UNAVAILABLE = 10'd503;

  // Arithmetic constants.
  localparam logic [19:0] NS_PER_MS    = 20'd1000000;
  localparam int          JITTER_SHIFT = 3;

  // Register reset values.
  localparam logic [31:0] MAX_BACKOFF_RESET     = 32'd300000;
  localparam logic [31:0] DEFAULT_BACKOFF_RESET = 32'd60000;

  // Width of the divider's divisor and remainder.
  localparam int DIVISOR_W = 30;

endpackage

>>> rtl/bdgj_div.sv
// Bit-serial restoring divider: 64-bit dividend, one quotient bit per cycle.
module bdgj_div import bdgj_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [63:0]          dividend,
  input  logic [DIVISOR_W-1:0] divisor,
  output div_stat_t            stat,
  output logic [63:0]          quotient,
  output logic [DIVISOR_W-1:0] remainder
);

  logic [DIVISOR_W-1:0] dvs;
  logic [DIVISOR_W-1:0] rem;
  logic [63:0]          quo;
  logic [5:0]           cnt;
  logic                 busy;
  logic                 done;
  logic [DIVISOR_W:0]   partial;
  logic                 ge;

  // One trial subtraction: bring down the next dividend bit.
  assign partial = {rem, quo[63]};
  assign ge      = partial >= {1'b0, dvs};

  // Shift registers for quotient and remainder, with the step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        quo  <= dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        if (ge) begin
          rem <= DIVISOR_W'(partial - {1'b0, dvs});
        end else begin
          rem <= partial[DIVISOR_W-1:0];
        end
        quo <= {quo[62:0], ge};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat      = '{busy: busy, done: done};
  assign quotient  = quo;
  assign remainder = rem;

endmodule

>>> rtl/backoff_deadline_gate_jitter_top.sv
// Backoff deadline gate: holds a 64-bit deadline and answers check and response transactions.
// A check divides the time still to run into milliseconds (skipped if the deadline has passed);
// an arming response first divides now_ns for the jitter, clamps and scales the window, adds it
// to form the deadline, then divides likewise. One transaction at a time, taken in idle only.
// Reset: synchronous rst clears the deadline to zero, loads the register defaults
// (maximum 300000 ms, default 60000 ms) and empties the output register.
module backoff_deadline_gate_jitter_top import bdgj_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output rsp_t        rsp,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_JITTER,
    S_MUL,
    S_ADD,
    S_DIFF,
    S_QUOT,
    S_DONE
  } state_t;

  state_t               state;
  logic [31:0]          max_backoff;
  logic [31:0]          default_backoff;
  logic [63:0]          deadline;
  logic [63:0]          now;
  logic [31:0]          window;
  logic                 armed;
  logic [51:0]          product;
  logic [44:0]          remaining;
  logic                 div_start;
  logic [63:0]          div_dividend;
  logic [DIVISOR_W-1:0] div_divisor;
  div_stat_t            div_stat;
  logic [63:0]          div_quotient;
  logic [DIVISOR_W-1:0] div_remainder;
  logic                 arm_hit;
  logic                 arm_go;
  logic [31:0]          arm_window;
  logic [32:0]          jittered;
  logic [64:0]          diff;
  logic                 req_fire;

  assign req_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign req_fire  = req_valid && req_ready;

  // Decide whether this transaction arms the window, and with which length.
  assign arm_hit = (req.operation == OP_RESPONSE) &&
                   ((req.status_code == STATUS_TOO_MANY) ||
                    (req.status_code == STATUS_UNAVAILABLE));
  always_comb begin
    arm_go     = 1'b0;
    arm_window = default_backoff;
    if (arm_hit) begin
      if (req.hint_valid) begin
        arm_go     = 1'b1;
        arm_window = req.hint_ms;
      end else if (req.status_code == STATUS_TOO_MANY) begin
        arm_go = 1'b1;
      end
    end
  end

  // Window plus jitter, and the time still to run before the deadline.
  assign jittered = {1'b0, window} + 33'(div_remainder);
  assign diff     = {1'b0, deadline} - {1'b0, now};

  // Divider operands: the jitter modulus or the nanoseconds-per-millisecond constant.
  always_comb begin
    div_start    = 1'b0;
    div_dividend = now;
    div_divisor  = DIVISOR_W'(NS_PER_MS);
    if (req_fire && arm_go) begin
      div_start    = 1'b1;
      div_dividend = req.now_ns;
      div_divisor  = DIVISOR_W'(arm_window[31:JITTER_SHIFT]) + DIVISOR_W'(1);
    end else if (state == S_DIFF && deadline > now) begin
      div_start    = 1'b1;
      div_dividend = diff[63:0];
    end
  end

  bdgj_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .stat      (div_stat),
    .quotient  (div_quotient),
    .remainder (div_remainder)
  );

  // Sequencer, configuration registers, deadline and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      max_backoff     <= MAX_BACKOFF_RESET;
      default_backoff <= DEFAULT_BACKOFF_RESET;
      deadline        <= '0;
      armed           <= 1'b0;
      rsp_valid       <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_MAX_BACKOFF:     max_backoff     <= cfg_data;
          REG_DEFAULT_BACKOFF: default_backoff <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (req_fire) begin
            now    <= req.now_ns;
            window <= arm_window;
            armed  <= arm_go;
            state  <= arm_go ? S_JITTER : S_DIFF;
          end
        end
        S_JITTER: begin
          if (div_stat.done) begin
            if (jittered > {1'b0, max_backoff}) begin
              window <= max_backoff;
            end else begin
              window <= jittered[31:0];
            end
            state <= S_MUL;
          end
        end
        S_MUL: begin
          product <= 52'(window) * 52'(NS_PER_MS);
          state   <= S_ADD;
        end
        S_ADD: begin
          deadline <= now + 64'(product);
          state    <= S_DIFF;
        end
        S_DIFF: begin
          if (deadline > now) begin
            state <= S_QUOT;
          end else begin
            remaining <= '0;
            state     <= S_DONE;
          end
        end
        S_QUOT: begin
          if (div_stat.done) begin
            remaining <= div_quotient[44:0];
            state     <= S_DONE;
          end
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp.verdict      <= armed || (remaining != '0) || (deadline > now);
            rsp.remaining_ms <= remaining;
            rsp_valid        <= 1'b1;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> dv/backoff_deadline_gate_jitter_top_test.sv
// Self-checking testbench for the backoff deadline gate with jitter.
module backoff_deadline_gate_jitter_top_test import bdgj_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CYCLE_LIMIT  = 1000000;
  localparam int          SETTLE_LIMIT = 300;
  localparam int          PARK_CYCLES  = 1200;
  localparam logic [63:0] NS_PER_MS_64 = 64'(NS_PER_MS);
  localparam logic [31:0] ALL_ONES_32  = 32'hFFFF_FFFF;
  localparam logic [63:0] ALL_ONES_64  = 64'hFFFF_FFFF_FFFF_FFFF;

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_ready;
  req_t        req;
  logic        rsp_valid;
  logic        rsp_ready;
  rsp_t        rsp;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [31:0] cfg_data;

  // Predictor state: a private copy of the deadline and both window registers.
  logic [63:0] predicted_deadline_ns;
  logic [31:0] max_window_ms;
  logic [31:0] default_window_ms;

  // Answers still owed by the block, oldest first.
  rsp_t        answers_due[$];

  int          failures;
  int          cycle_count;
  bit          gaps_enabled;
  int          park_request;
  logic [63:0] mono_ns;

  backoff_deadline_gate_jitter_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Free-running clock, 2 ns period.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Works out the answer to one transaction and moves the predicted deadline.
  function automatic rsp_t answer_gate(req_t r);
    logic [63:0] window;
    logic [63:0] jitter;
    logic        armed;
    rsp_t        a;
    armed  = 1'b0;
    window = '0;
    if (r.operation == OP_RESPONSE &&
        (r.status_code == STATUS_TOO_MANY || r.status_code == STATUS_UNAVAILABLE)) begin
      if (r.hint_valid) begin
        window = 64'(r.hint_ms);
        armed  = 1'b1;
      end else if (r.status_code == STATUS_TOO_MANY) begin
        window = 64'(default_window_ms);
        armed  = 1'b1;
      end
    end
    if (armed) begin
      jitter = r.now_ns % ((window >> JITTER_SHIFT) + 64'd1);
      window = window + jitter;
      if (window > 64'(max_window_ms)) begin
        window = 64'(max_window_ms);
      end
      predicted_deadline_ns = r.now_ns + window * NS_PER_MS_64;
    end
    a.verdict = armed || (predicted_deadline_ns > r.now_ns);
    if (predicted_deadline_ns > r.now_ns) begin
      a.remaining_ms = 45'((predicted_deadline_ns - r.now_ns) / NS_PER_MS_64);
    end else begin
      a.remaining_ms = '0;
    end
    return a;
  endfunction

  function automatic req_t make_req(logic op, logic [63:0] now, logic [9:0] status,
                                    logic hint_ok, logic [31:0] hint);
    req_t r;
    r.operation   = op;
    r.now_ns      = now;
    r.status_code = status;
    r.hint_valid  = hint_ok;
    r.hint_ms     = hint;
    return r;
  endfunction

  // Offers one transaction and returns at the edge where it is taken. Valid is
  // left high so that a following transaction can go out back to back.
  task automatic send_request(input req_t item);
    int gap;
    if (gaps_enabled && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (!req_ready);
    answers_due.push_back(answer_gate(item));
  endtask

  // Stops offering and waits until every owed answer has come back.
  task automatic wait_for_answers();
    req_valid <= 1'b0;
    do @(posedge clk); while (answers_due.size() != 0);
  endtask

  // Writes both window registers; the block must be idle.
  task automatic set_windows(input logic [31:0] max_ms, input logic [31:0] def_ms);
    cfg_valid <= 1'b1;
    cfg_index <= REG_MAX_BACKOFF;
    cfg_data  <= max_ms;
    do @(posedge clk); while (!cfg_ready);
    max_window_ms = max_ms;
    cfg_index <= REG_DEFAULT_BACKOFF;
    cfg_data  <= def_ms;
    do @(posedge clk); while (!cfg_ready);
    default_window_ms = def_ms;
    cfg_valid <= 1'b0;
  endtask

  // Checks, arming and the special status cases under the reset register values.
  task automatic test_check_and_arm();
    send_request(make_req(OP_CHECK, 64'd0, 10'd0, 1'b0, 32'd0));
    send_request(make_req(OP_RESPONSE, 64'd1000, STATUS_TOO_MANY, 1'b0, ALL_ONES_32));
    send_request(make_req(OP_CHECK, 64'd2000, 10'd0, 1'b0, 32'd0));
    send_request(make_req(OP_CHECK, ALL_ONES_64, 10'h3FF, 1'b1, ALL_ONES_32));
    // A 503 without a hint only reports the state.
    send_request(make_req(OP_RESPONSE, 64'd5000, STATUS_UNAVAILABLE, 1'b0, 32'd700));
    // Other status codes, including those beyond the legal HTTP range.
    send_request(make_req(OP_RESPONSE, 64'd6000, 10'd200, 1'b1, 32'd5000));
    send_request(make_req(OP_RESPONSE, 64'd7000, 10'd1023, 1'b1, 32'd5000));
    send_request(make_req(OP_RESPONSE, 64'd8000, 10'd0, 1'b0, 32'd0));
    // A check carrying an arming status must not arm.
    send_request(make_req(OP_CHECK, 64'd9000, STATUS_TOO_MANY, 1'b1, 32'd5000));
    // A zero hint arms a window that has already expired.
    send_request(make_req(OP_RESPONSE, 64'd10000, STATUS_UNAVAILABLE, 1'b1, 32'd0));
    // The largest hint is clamped to the maximum.
    send_request(make_req(OP_RESPONSE, 64'h0123_4567_89AB_CDEF, STATUS_TOO_MANY, 1'b1,
                          ALL_ONES_32));
    // A deadline far ahead gives a large remaining count.
    send_request(make_req(OP_RESPONSE, 64'h8000_0000_0000_0000, STATUS_UNAVAILABLE, 1'b1,
                          32'd1000));
    send_request(make_req(OP_CHECK, 64'd0, 10'd0, 1'b0, 32'd0));
    // The deadline wraps past the top of the clock.
    send_request(make_req(OP_RESPONSE, 64'hFFFF_FFFF_FFFF_0000, STATUS_TOO_MANY, 1'b1,
                          32'd1000));
    send_request(make_req(OP_CHECK, 64'd0, 10'd0, 1'b0, 32'd0));
    wait_for_answers();
  endtask

  // Both registers at their extremes.
  task automatic test_register_extremes();
    set_windows(32'd0, 32'd0);
    send_request(make_req(OP_RESPONSE, 64'd77, STATUS_TOO_MANY, 1'b0, 32'd0));
    send_request(make_req(OP_RESPONSE, 64'd12345, STATUS_UNAVAILABLE, 1'b1, ALL_ONES_32));
    send_request(make_req(OP_CHECK, 64'd12345, 10'd0, 1'b0, 32'd0));
    wait_for_answers();
    set_windows(ALL_ONES_32, ALL_ONES_32);
    send_request(make_req(OP_RESPONSE, 64'd0, STATUS_TOO_MANY, 1'b0, 32'd0));
    send_request(make_req(OP_CHECK, 64'd1, 10'd0, 1'b0, 32'd0));
    send_request(make_req(OP_RESPONSE, 64'h0000_0FFF_FFFF_FFFF, STATUS_UNAVAILABLE, 1'b1,
                          ALL_ONES_32));
    wait_for_answers();
  endtask

  // The receiver parks for a long stretch while transactions keep coming, so
  // the block fills and must hold off its input.
  task automatic test_output_stall();
    set_windows(MAX_BACKOFF_RESET, DEFAULT_BACKOFF_RESET);
    gaps_enabled = 1'b0;
    park_request = PARK_CYCLES;
    for (int i = 0; i < 8; i++) begin
      mono_ns += 64'($urandom_range(0, 5000)) * NS_PER_MS_64;
      send_request(make_req(1'($urandom), mono_ns, i[0] ? STATUS_TOO_MANY : STATUS_UNAVAILABLE,
                            1'($urandom), $urandom_range(0, 20000)));
    end
    wait_for_answers();
    gaps_enabled = 1'b1;
  endtask

  // Mostly plausible traffic on a rising clock, with some noise mixed in.
  task automatic run_traffic(input int count, input int advance_ms_max, input int hint_ms_max);
    int   pick;
    req_t item;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      mono_ns += 64'($urandom_range(0, advance_ms_max)) * NS_PER_MS_64
                 + 64'($urandom_range(0, 999999));
      if (pick < 55) begin
        item = make_req(OP_CHECK, mono_ns, 10'($urandom_range(0, 1023)), 1'($urandom),
                        $urandom);
      end else if (pick < 80) begin
        item = make_req(OP_RESPONSE, mono_ns,
                        $urandom_range(0, 1) ? STATUS_TOO_MANY : STATUS_UNAVAILABLE,
                        1'($urandom_range(0, 2) != 0),
                        ($urandom_range(0, 5) == 0) ? $urandom
                                                    : $urandom_range(0, hint_ms_max));
      end else if (pick < 90) begin
        item = make_req(OP_RESPONSE, mono_ns, 10'($urandom_range(0, 1023)), 1'($urandom),
                        $urandom);
      end else begin
        // Noise: every field random, time included.
        item = make_req(1'($urandom), {$urandom, $urandom}, 10'($urandom), 1'($urandom),
                        $urandom);
      end
      send_request(item);
    end
  endtask

  task automatic test_random_traffic();
    run_traffic(250, 20000, 60000);
    wait_for_answers();
    set_windows(32'd20000, 32'd3000);
    run_traffic(200, 4000, 8000);
    wait_for_answers();
    set_windows(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 50000),
                $urandom_range(0, 30000));
    run_traffic(150, 8000, 40000);
    wait_for_answers();
  endtask

  // Closing stretch with neither side idling.
  task automatic test_full_rate();
    set_windows(32'd5000, 32'd1000);
    gaps_enabled = 1'b0;
    run_traffic(150, 2000, 6000);
    wait_for_answers();
  endtask

  // Result ready: random stall bursts, plus the long park a test can ask for.
  initial begin : rsp_ready_ctl
    int stall_left;
    int park_left;
    rsp_ready  = 1'b0;
    stall_left = 0;
    park_left  = 0;
    forever begin
      @(posedge clk);
      if (park_request != 0) begin
        park_left    = park_request;
        park_request = 0;
      end
      if (rst) begin
        rsp_ready <= 1'b0;
      end else if (park_left > 0) begin
        park_left--;
        rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_ready <= 1'b0;
      end else if (gaps_enabled && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 17) - 1;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // Compares each accepted result transaction with the oldest owed answer.
  always @(posedge clk) begin : check_answers
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (answers_due.size() == 0) begin
        $error("unexpected result: verdict %0b remaining_ms %0d", rsp.verdict,
               rsp.remaining_ms);
        failures++;
      end else begin
        want = answers_due.pop_front();
        if (rsp.verdict !== want.verdict) begin
          $error("verdict: expected %0b, actual %0b", want.verdict, rsp.verdict);
          failures++;
        end
        if (rsp.remaining_ms !== want.remaining_ms) begin
          $error("remaining_ms: expected %0d, actual %0d", want.remaining_ms,
                 rsp.remaining_ms);
          failures++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst          = 1'b1;
    req_valid    = 1'b0;
    req          = '0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_MAX_BACKOFF;
    cfg_data     = '0;
    failures     = 0;
    cycle_count  = 0;
    gaps_enabled = 1'b1;
    park_request = 0;
    mono_ns      = {2'b00, $urandom, 30'($urandom)};

    predicted_deadline_ns = '0;
    max_window_ms         = MAX_BACKOFF_RESET;
    default_window_ms     = DEFAULT_BACKOFF_RESET;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_check_and_arm();
    test_register_extremes();
    test_output_stall();
    test_random_traffic();
    test_full_rate();

    // Let any stray result show itself before the verdict.
    repeat (SETTLE_LIMIT) @(posedge clk);
    if (failures == 0 && answers_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
